@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file of the piece decoder.
// Depends on a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checked at every edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

@@ sv/bpd_pkg.sv @@
// Package for the byte-level BPE piece decoder: sizes, byte codes, result types
// and the inverse byte-to-unicode table. No dependencies.
package bpd_pkg;

  localparam int unsigned MAX_PIECE_BYTES = 511;
  localparam int unsigned CNT_W           = $clog2(MAX_PIECE_BYTES + 1);

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] LEAD_MASK   = 8'hE0;
  localparam logic [7:0] LEAD2_TAG   = 8'hC0;
  localparam logic [7:0] CONT_MASK   = 8'hC0;
  localparam logic [7:0] CONT_TAG    = 8'h80;
  localparam logic [7:0] LEAD_BITS   = 8'h1F;
  localparam logic [7:0] CONT_BITS   = 8'h3F;
  localparam logic [7:0] SPACE_LEAD  = 8'hC4;
  localparam logic [7:0] SPACE_CONT  = 8'hA0;
  localparam logic [7:0] ASCII_SPACE = 8'h20;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       piece_end;
  } result_t;

  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t ent0;
    result_t ent1;
  } push_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] raw;
  } map_t;

  // Inverse GPT-2 byte-to-unicode table over codepoints 0x000..0x7FF.
  function automatic map_t cp_to_byte(input logic [10:0] cp);
    map_t m;
    m.hit = 1'b0;
    m.raw = cp[7:0];
    if ((cp >= 11'h021 && cp <= 11'h07E) || (cp >= 11'h0A1 && cp <= 11'h0AC) ||
        (cp >= 11'h0AE && cp <= 11'h0FF)) begin
      m.hit = 1'b1;
    end else if (cp >= 11'h100 && cp <= 11'h120) begin
      m.hit = 1'b1;
    end else if (cp >= 11'h121 && cp <= 11'h142) begin
      m.hit = 1'b1;
      m.raw = cp[7:0] + 8'h5E;
    end else if (cp == 11'h143) begin
      m.hit = 1'b1;
      m.raw = 8'hAD;
    end
    return m;
  endfunction

endpackage

@@ sv/byte_level_bpe_piece_decoder_core.sv @@
// Top level of the byte-level BPE piece decoder: per-byte decode and piece
// state. Depends on bpd_pkg and bpd_out_fifo.
//
// Usage:
//  - Slave stream s_axis_*: one UTF-8 byte of a token piece per transaction,
//    tuser = strip flag (sampled on the first byte of a piece), tlast marks
//    the final byte of the piece.
//  - Master stream m_axis_*: one decoded raw byte per transaction, tuser = 1
//    when tdata carries a byte, 0 for an empty end marker; tlast marks the
//    final result of the piece.
//  - Output: each result is written into the result queue when the byte that
//    produced it is accepted. A held 2-byte lead produces nothing until
//    its next byte arrives.
//  - Throughput: one byte per cycle. A byte that flushes two results (lead
//    copied raw plus the new byte) needs two output transfers; the 4-entry
//    result queue absorbs the second, and s_axis_tready drops once fewer
//    than two entries are free.
//  - Reset: queue empties, the next byte starts a new piece.
//  - Receiver stall: results wait in the queue; input keeps flowing until
//    the queue cannot take two more results.
module byte_level_bpe_piece_decoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tuser,   // [0] strip_space
  input  logic       s_axis_tlast,   // in_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // [0] byte_valid
  output logic       m_axis_tlast    // piece_end
);
  import bpd_pkg::*;

  // Piece state
  logic [7:0]       pending_lead;
  logic             pending_valid;
  logic [CNT_W-1:0] emitted_count;
  logic             at_piece_start;
  logic             strip_armed;

  logic [7:0]       pending_lead_next;
  logic             pending_valid_next;
  logic [CNT_W-1:0] emitted_count_next;
  logic             at_piece_start_next;
  logic             strip_armed_next;

  logic             accept;
  logic [7:0]       b;
  logic             last;
  logic             armed;
  logic             armed_n;
  logic [CNT_W-1:0] cnt;
  logic             want0;
  logic             want1;
  logic [7:0]       c0;
  logic [7:0]       c1;
  logic             pend_n;
  logic             e0;
  logic             e1;
  logic [CNT_W:0]   cnt_e0;
  logic             is_cont;
  logic             is_lead2;
  map_t             map;
  push_t            push;
  logic             room;
  logic             nonempty;
  result_t          head;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign b        = s_axis_tdata;
  assign last     = s_axis_tlast;
  assign is_cont  = ((b & CONT_MASK) == CONT_TAG);
  assign is_lead2 = ((b & LEAD_MASK) == LEAD2_TAG);
  assign map      = cp_to_byte({pending_lead[4:0] & LEAD_BITS[4:0],
                                b[5:0] & CONT_BITS[5:0]});

  // Decode one byte into up to two candidate results
  always_comb begin
    armed  = at_piece_start ? s_axis_tuser : strip_armed;
    cnt    = at_piece_start ? '0 : emitted_count;
    armed_n = armed;
    want0  = 1'b0;
    want1  = 1'b0;
    c0     = b;
    c1     = b;
    pend_n = 1'b0;
    if (pending_valid) begin
      armed_n = 1'b0;
      if (is_cont) begin
        // drop a leading U+0120 when stripping is armed
        if (!(armed && pending_lead == SPACE_LEAD && b == SPACE_CONT)) begin
          want0 = 1'b1;
          if (map.hit) begin
            c0 = map.raw;
          end else begin
            c0    = pending_lead;
            want1 = 1'b1;
          end
        end
      end else begin
        // flush the lead raw, then take the byte afresh
        want0 = 1'b1;
        c0    = pending_lead;
        if (!b[7] || !is_lead2 || last) begin
          want1 = 1'b1;
        end else begin
          pend_n = 1'b1;
        end
      end
    end else begin
      if (!b[7]) begin
        armed_n = 1'b0;
        want0   = !(armed && b == ASCII_SPACE);
      end else if (is_lead2 && !last) begin
        pend_n = 1'b1;
      end else begin
        armed_n = 1'b0;
        want0   = 1'b1;
      end
    end
  end

  // Apply the per-piece byte cap
  always_comb begin
    e0     = want0 && ({1'b0, cnt} < (CNT_W + 1)'(MAX_PIECE_BYTES));
    cnt_e0 = {1'b0, cnt} + (CNT_W + 1)'(e0);
    e1     = want1 && (cnt_e0 < (CNT_W + 1)'(MAX_PIECE_BYTES));
  end

  // Build the queue writes
  always_comb begin
    push.push0 = accept && (e0 || e1 || last);
    push.push1 = accept && e0 && e1;
    push.ent1  = '{data: c1, byte_valid: 1'b1, piece_end: last};
    if (e0 && e1) begin
      push.ent0 = '{data: c0, byte_valid: 1'b1, piece_end: 1'b0};
    end else if (e0 || e1) begin
      push.ent0 = '{data: (e0 ? c0 : c1), byte_valid: 1'b1, piece_end: last};
    end else begin
      // empty end marker
      push.ent0 = '{data: 8'h00, byte_valid: 1'b0, piece_end: 1'b1};
    end
  end

  // Next piece state
  always_comb begin
    pending_lead_next   = pending_lead;
    pending_valid_next  = pending_valid;
    emitted_count_next  = emitted_count;
    at_piece_start_next = at_piece_start;
    strip_armed_next    = strip_armed;
    if (accept) begin
      if (last) begin
        pending_lead_next   = 8'h00;
        pending_valid_next  = 1'b0;
        emitted_count_next  = '0;
        at_piece_start_next = 1'b1;
        strip_armed_next    = 1'b0;
      end else begin
        pending_lead_next   = pend_n ? b : 8'h00;
        pending_valid_next  = pend_n;
        emitted_count_next  = cnt + CNT_W'(e0) + CNT_W'(e1);
        at_piece_start_next = 1'b0;
        strip_armed_next    = armed_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_lead   <= 8'h00;
      pending_valid  <= 1'b0;
      emitted_count  <= '0;
      at_piece_start <= 1'b1;
      strip_armed    <= 1'b0;
    end else begin
      pending_lead   <= pending_lead_next;
      pending_valid  <= pending_valid_next;
      emitted_count  <= emitted_count_next;
      at_piece_start <= at_piece_start_next;
      strip_armed    <= strip_armed_next;
    end
  end

  bpd_out_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pop      (m_axis_tready),
    .room     (room),
    .nonempty (nonempty),
    .head     (head)
  );

  assign s_axis_tready = room;
  assign m_axis_tvalid = nonempty;
  assign m_axis_tdata  = head.data;
  assign m_axis_tuser  = head.byte_valid;
  assign m_axis_tlast  = head.piece_end;

endmodule

@@ sv/bpd_out_fifo.sv @@
// Four-entry result queue of the piece decoder: takes up to two results a
// cycle, hands out one. Depends on bpd_pkg.
module bpd_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  bpd_pkg::push_t   push,
  input  logic             pop,
  output logic             room,
  output logic             nonempty,
  output bpd_pkg::result_t head
);
  import bpd_pkg::*;

  result_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_CW-1:0]   count;
  logic [FIFO_AW-1:0]   wr_ptr1;
  logic [FIFO_CW-1:0]   count_next;

  assign wr_ptr1  = wr_ptr + FIFO_AW'(1);
  assign nonempty = (count != '0);
  assign room     = (count <= FIFO_CW'(FIFO_DEPTH - 2));
  assign head     = mem[rd_ptr];

  always_comb begin
    count_next = count + FIFO_CW'(push.push0) + FIFO_CW'(push.push1)
                 - FIFO_CW'(pop && nonempty);
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr_ptr] <= push.ent0;
    end
    if (push.push1) begin
      mem[wr_ptr1] <= push.ent1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push.push0) + FIFO_AW'(push.push1);
      if (pop && nonempty) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count_next;
    end
  end

endmodule

@@ sv/bpd_checker.sv @@
// Port-level checker for the piece decoder, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module bpd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tuser,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       m_axis_tlast
);

  // hold a stalled result
  `ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

  // an empty marker only closes a piece and carries zero
  `ASSERT_CLK(a_empty_end, m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 8'h00)

  // the last byte of a piece always yields a result
  `ASSERT_CLK(a_last_result, s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)

  // no result right after reset
  `ASSERT_CLK_ALWAYS(a_reset_empty, rst |=> !m_axis_tvalid)

endmodule

bind byte_level_bpe_piece_decoder_core bpd_checker u_bpd_checker (.*);

@@ tb/testbench.sv @@
// Self-checking bench for byte_level_bpe_piece_decoder_core: it drives token-piece bytes
// and checks every decoded result against an in-bench model of the inverse byte map.
// Depends on bpd_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module testbench;
  import bpd_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int RESET_LEN   = 9;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [7:0] b;
    logic       strip;
    logic       last;
  } piece_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_valid = 1'b0;
  logic [7:0] s_data = 8'h00;
  logic       s_strip = 1'b0;
  logic       s_last = 1'b0;
  logic       m_ready = 1'b0;
  logic       s_axis_tready;
  logic       m_axis_tvalid;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;
  logic       m_axis_tlast;

  byte_level_bpe_piece_decoder_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),   // [7:0] in_byte
    .s_axis_tuser  (s_strip),  // [0] strip_space
    .s_axis_tlast  (s_last),   // in_last
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),  // [7:0] out_byte
    .m_axis_tuser  (m_axis_tuser),  // [0] byte_valid
    .m_axis_tlast  (m_axis_tlast)   // piece_end
  );

  always #CLK_HALF clk = ~clk;

  piece_byte_t piece_bytes_q[$];
  result_t     decoded_q[$];

  // Idle limits per side, set by the sequence below.
  int tx_gap_max = 0;
  int rx_stall_max = 0;
  int hold_requests = 0;

  int errors = 0;
  int bytes_sent = 0;
  int pieces_sent = 0;
  int results_seen = 0;
  int empty_ends = 0;
  int cycles = 0;

  // Decoder model state
  logic [7:0] lead_byte = 8'h00;
  logic       lead_held = 1'b0;
  int         emit_cnt = 0;
  logic       new_piece = 1'b1;
  logic       strip_on = 1'b0;
  result_t    step_out[2];
  int         step_n;

  // Inverse GPT-2 byte map; -1 when the codepoint has no raw byte.
  function automatic int unmap_cp(input int cp);
    if ((cp >= 'h21 && cp <= 'h7E) || (cp >= 'hA1 && cp <= 'hAC) ||
        (cp >= 'hAE && cp <= 'hFF)) return cp;
    if (cp >= 'h100 && cp <= 'h120) return cp - 'h100;
    if (cp >= 'h121 && cp <= 'h142) return cp - 'h121 + 'h7F;
    if (cp == 'h143) return 'hAD;
    return -1;
  endfunction

  // Emit one raw byte unless the piece already hit its byte cap.
  task automatic add_out(input logic [7:0] b);
    if (emit_cnt >= MAX_PIECE_BYTES) return;
    emit_cnt++;
    step_out[step_n] = '{data: b, byte_valid: 1'b1, piece_end: 1'b0};
    step_n++;
  endtask

  // A byte that opens a new codepoint: ASCII, 2-byte lead, or raw copy.
  task automatic start_codepoint(input logic [7:0] b, input logic last);
    if (b < CONT_TAG) begin
      if (!(strip_on && b == ASCII_SPACE)) add_out(b);
      strip_on = 1'b0;
    end else if ((b & LEAD_MASK) == LEAD2_TAG && !last) begin
      lead_byte = b;
      lead_held = 1'b1;
    end else begin
      strip_on = 1'b0;
      add_out(b);
    end
  endtask

  // Work out the results one accepted byte causes and queue them.
  task automatic decode_piece_byte(input piece_byte_t it);
    int         cp;
    int         m;
    logic [7:0] ld;
    step_n = 0;
    if (new_piece) begin
      strip_on = it.strip;
      emit_cnt = 0;
      new_piece = 1'b0;
    end
    if (lead_held) begin
      ld = lead_byte;
      lead_held = 1'b0;
      if ((it.b & CONT_MASK) == CONT_TAG) begin
        cp = (int'(ld & LEAD_BITS) << 6) | int'(it.b & CONT_BITS);
        m = unmap_cp(cp);
        // Drop the space marker only as the first codepoint of a stripped piece.
        if (!(strip_on && ld == SPACE_LEAD && it.b == SPACE_CONT)) begin
          if (m >= 0) begin
            add_out(m[7:0]);
          end else begin
            add_out(ld);
            add_out(it.b);
          end
        end
        strip_on = 1'b0;
      end else begin
        // Broken sequence: copy the lead raw, then decode the new byte afresh.
        strip_on = 1'b0;
        add_out(ld);
        start_codepoint(it.b, it.last);
      end
    end else begin
      start_codepoint(it.b, it.last);
    end
    if (it.last) begin
      if (step_n > 0) begin
        step_out[step_n - 1].piece_end = 1'b1;
      end else begin
        step_out[0] = '{data: 8'h00, byte_valid: 1'b0, piece_end: 1'b1};
        step_n = 1;
      end
      lead_held = 1'b0;
      emit_cnt = 0;
      strip_on = 1'b0;
      new_piece = 1'b1;
    end
    for (int i = 0; i < step_n; i++) decoded_q.push_back(step_out[i]);
  endtask

  // Driver: present queued bytes, idle a random number of cycles between them.
  int          tx_gap = 0;
  logic        tx_busy = 1'b0;
  piece_byte_t tx_cur;

  always @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_axis_tready) begin
        decode_piece_byte(tx_cur);
        bytes_sent++;
        if (tx_cur.last) pieces_sent++;
        tx_busy = 1'b0;
        tx_gap = $urandom_range(0, tx_gap_max);
      end
      if (!tx_busy) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_valid <= 1'b0;
        end else if (piece_bytes_q.size() > 0) begin
          tx_cur = piece_bytes_q.pop_front();
          tx_busy = 1'b1;
          s_data <= tx_cur.b;
          s_strip <= tx_cur.strip;
          s_last <= tx_cur.last;
          s_valid <= 1'b1;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction, stall the receiver at random.
  int      rx_stall = 0;
  int      rx_hold = 0;
  int      hold_taken = 0;
  result_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_ready) begin
        results_seen++;
        if (!m_axis_tuser) empty_ends++;
        if (decoded_q.size() == 0) begin
          $error("result with nothing expected: out_byte %h byte_valid %b piece_end %b",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          errors++;
        end else begin
          want = decoded_q.pop_front();
          if (m_axis_tdata !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, m_axis_tdata);
            errors++;
          end
          if (m_axis_tuser !== want.byte_valid) begin
            $error("byte_valid: expected %b, got %b", want.byte_valid, m_axis_tuser);
            errors++;
          end
          if (m_axis_tlast !== want.piece_end) begin
            $error("piece_end: expected %b, got %b", want.piece_end, m_axis_tlast);
            errors++;
          end
        end
        rx_stall = $urandom_range(0, rx_stall_max);
      end
      if (hold_taken != hold_requests) begin
        hold_taken = hold_requests;
        rx_hold = HOLD_CYCLES;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic put(input logic [7:0] b, input logic strip, input logic last);
    piece_bytes_q.push_back('{b: b, strip: strip, last: last});
  endtask

  task automatic put_rand(input logic [7:0] b, input logic last);
    put(b, 1'($urandom_range(0, 1)), last);
  endtask

  // Hold the sender until every queued byte went out and every result came back.
  task automatic wait_drained();
    while (piece_bytes_q.size() > 0 || tx_busy || decoded_q.size() > 0) @(posedge clk);
  endtask

  // Mostly well-formed text with spaces and 2-byte codepoints, some raw noise.
  task automatic queue_random_piece(output int n_bytes);
    int         len;
    int         k;
    int         pick;
    logic [7:0] b;
    len = $urandom_range(1, 10);
    k = 0;
    while (k < len) begin
      pick = $urandom_range(0, 99);
      if (pick < 10 && k + 1 < len) begin
        put_rand(SPACE_LEAD, 1'b0);
        put_rand(SPACE_CONT, k + 2 == len);
        k += 2;
      end else if (pick < 40 && k + 1 < len) begin
        b = $urandom_range(0, 1) ? 8'($urandom_range('hC4, 'hC5))
                                 : 8'($urandom_range('hC0, 'hDF));
        put_rand(b, 1'b0);
        put_rand(8'($urandom_range('h80, 'hBF)), k + 2 == len);
        k += 2;
      end else begin
        if (pick < 50) b = ASCII_SPACE;
        else if (pick < 80) b = 8'($urandom_range('h21, 'h7E));
        else b = 8'($urandom_range(1, 255));
        put_rand(b, k + 1 == len);
        k++;
      end
    end
    n_bytes = len;
  endtask

  task automatic run_random(input int n_items, input int tx_max, input int rx_max,
                            input bit hold_rx);
    int queued;
    int got;
    tx_gap_max = tx_max;
    rx_stall_max = rx_max;
    queued = 0;
    while (queued < n_items) begin
      queue_random_piece(got);
      queued += got;
    end
    // Hold off the receiver while the sender keeps pushing, so the input stalls.
    if (hold_rx) hold_requests++;
    wait_drained();
  endtask

  initial begin
    tx_gap_max = 13;
    rx_stall_max = 13;

    // Directed pieces
    put('h41, 1'b0, 1'b1);                           // plain ASCII
    put(ASCII_SPACE, 1'b1, 1'b0); put('h62, 1'b0, 1'b1); // literal space stripped
    put(SPACE_LEAD, 1'b1, 1'b0); put(SPACE_CONT, 1'b0, 1'b0);
    put('h63, 1'b1, 1'b1);                           // marker stripped
    put(SPACE_LEAD, 1'b0, 1'b0); put(SPACE_CONT, 1'b0, 1'b1); // marker kept as space
    put(ASCII_SPACE, 1'b1, 1'b1);                    // whole piece stripped: empty end
    put('hC5, 1'b0, 1'b0); put('h83, 1'b0, 1'b1);    // top of the mapped range
    put('hC6, 1'b0, 1'b0); put('h80, 1'b1, 1'b1);    // unmapped codepoint, both raw
    put('hC1, 1'b0, 1'b0); put('hA1, 1'b0, 1'b0);    // overlong form, mapped
    put('hC0, 1'b0, 1'b0); put('h80, 1'b0, 1'b1);    // overlong zero, unmapped
    put('hC3, 1'b0, 1'b0); put('h41, 1'b0, 1'b1);    // lead then ASCII
    put('hDF, 1'b0, 1'b0); put('hC5, 1'b0, 1'b0);    // lead then lead
    put('h82, 1'b0, 1'b1);
    put('hD0, 1'b1, 1'b1);                           // lone lead on last byte
    put('hFF, 1'b0, 1'b0); put('h01, 1'b1, 1'b0);    // byte extremes
    put('h80, 1'b0, 1'b0); put('hE0, 1'b1, 1'b1);
    put('h78, 1'b1, 1'b0); put(ASCII_SPACE, 1'b1, 1'b1); // strip disarmed by first cp
    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;
    wait_drained();

    run_random(20, 0, 0, 1'b0);      // back to back, no idling
    run_random(20, 0, 13, 1'b1);     // receiver stalls plus one long hold
    run_random(20, 13, 0, 1'b0);     // sender gaps only
    run_random(20, 13, 13, 1'b0);    // both sides idle

    // Byte cap: a 2-byte unmapped pair straddles the cap, the rest is dropped.
    tx_gap_max = 0;
    rx_stall_max = 3;
    for (int i = 0; i < MAX_PIECE_BYTES - 1; i++) begin
      put_rand(8'($urandom_range('h21, 'h7E)), 1'b0);
    end
    put_rand('hC6, 1'b0);
    put_rand('h80, 1'b0);
    repeat (4) put_rand(8'($urandom_range('h21, 'h7E)), 1'b0);
    put_rand('h41, 1'b1);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d bytes in %0d pieces; checked %0d results, %0d of them empty ends.",
             bytes_sent, pieces_sent, results_seen, empty_ends);
    $display("Covered strip, broken and overlong sequences, byte cap and stall phases.");
    if (errors == 0 && decoded_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/bpd_pkg.sv
sv/bpd_out_fifo.sv
sv/byte_level_bpe_piece_decoder_core.sv
sv/bpd_checker.sv
tb/testbench.sv
